// ----- design/pmpc_pkg.sv -----
// Shared types, codes and helpers for the physical memory protection check unit.
// No dependencies; imported by pmpc_entry and physical_memory_protection_check_unit.
package pmpc_pkg;

   // Beat layout widths
   localparam int unsigned IdxW    = 4;
   localparam int unsigned CfgW    = 8;
   localparam int unsigned EntAddrW = 54;
   localparam int unsigned AddrW   = 64;
   localparam int unsigned LenW    = 4;
   localparam int unsigned KindW   = 2;
   localparam int unsigned PrivW   = 2;
   localparam int unsigned ReqDataW = 144;
   localparam int unsigned RspDataW = 8;

   // An access covers at most four 4-byte words (length field is 4 bits)
   localparam int unsigned Words = 4;
   localparam int unsigned WordBytes = 4;

   // Configuration byte bit positions
   localparam int unsigned CfgR = 0;
   localparam int unsigned CfgW_BIT = 1;
   localparam int unsigned CfgX = 2;
   localparam int unsigned CfgModeLo = 3;
   localparam int unsigned CfgL = 7;

   typedef enum logic [1:0] {
      MODE_OFF   = 2'd0,
      MODE_TOR   = 2'd1,
      MODE_NA4   = 2'd2,
      MODE_NAPOT = 2'd3
   } mode_type;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_CHECK = 1'b1
   } op_type;

   localparam logic [KindW-1:0] KIND_FETCH = 2'd0;
   localparam logic [KindW-1:0] KIND_LOAD  = 2'd1;
   localparam logic [KindW-1:0] KIND_STORE = 2'd2;

   localparam logic [PrivW-1:0] PRIV_MACHINE = 2'd3;

   // Per-entry word match results
   typedef struct packed {
      logic [Words-1:0] lt;   // word address below this entry's top
      logic [Words-1:0] hit;  // word falls inside this entry's region
   } match_type;

   function automatic logic permit(input logic [CfgW-1:0] cfg,
                                   input logic [KindW-1:0] kind,
                                   input logic [PrivW-1:0] priv);
      logic ok;
      ok = (priv == PRIV_MACHINE) && !cfg[CfgL];
      case (kind)
         KIND_FETCH: ok = ok | cfg[CfgX];
         KIND_LOAD:  ok = ok | cfg[CfgR];
         KIND_STORE: ok = ok | cfg[CfgW_BIT];
         default:    ok = ok;
      endcase
      return ok;
   endfunction

endpackage

// ----- design/pmpc_entry.sv -----
// Address match for one protection entry against up to four access words.
// Depends on pmpc_pkg.
module pmpc_entry
   import pmpc_pkg::*;
(
   input  logic [EntAddrW-1:0]          entry_addr,
   input  logic [1:0]                   entry_mode,
   input  logic [Words-1:0]             prev_lt,     // words below the previous top
   input  logic [Words-1:0][AddrW-1:0]  word_addr,
   output match_type                    match
);

   logic [AddrW-1:0] top;
   logic [AddrW-1:0] m;
   logic [AddrW-1:0] ones;
   logic [AddrW-1:0] mask;
   mode_type         mode;

   assign mode = mode_type'(entry_mode);
   assign top  = {{(AddrW-EntAddrW-2){1'b0}}, entry_addr, 2'b00};

   // Trailing-ones run of the address word (plus one bit for NAPOT) is masked off
   assign m    = {{(AddrW-EntAddrW-1){1'b0}}, entry_addr, (mode == MODE_NA4) ? 1'b0 : 1'b1};
   assign ones = m & ~(m + 64'd1);
   assign mask = {~ones[AddrW-3:0], 2'b00};

   always_comb begin
      for (int k = 0; k < Words; k++) begin
         match.lt[k] = word_addr[k] < top;
         if (mode == MODE_TOR) begin
            match.hit[k] = !prev_lt[k] && match.lt[k];
         end else begin
            match.hit[k] = ((word_addr[k] ^ top) & mask) == '0;
         end
      end
   end

endmodule

// ----- design/physical_memory_protection_check_unit.sv -----
// Physical memory protection check unit: entry table, input and result registers.
// Depends on pmpc_pkg and pmpc_entry.

// Accepts one beat per clock unless a check is stalled by a full result register.
// A write beat (tuser 0) updates one protection entry and produces no result; a
// check beat (tuser 1) returns one allowed bit, registered first in the input
// register, where all entries are matched in parallel and the lowest-index
// matching entry decides, and then in the result register. Writes take effect
// for every check accepted after them. After reset all entries are off, so only
// machine mode is granted. Write indexes at or above ENTRIES are ignored.
module physical_memory_protection_check_unit
   import pmpc_pkg::*;
#(
   parameter int unsigned ENTRIES = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   // op
   input  logic                req_tuser,
   // entry_index, entry_cfg, entry_addr, check_addr, access_len, access_kind,
   // privilege, zero pad
   input  logic [ReqDataW-1:0] req_tdata,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // allowed, zero pad
   output logic [RspDataW-1:0] rsp_tdata
);

   // Input register
   logic                s1_valid_ff, s1_valid_in;
   op_type              s1_op_ff;
   logic [IdxW-1:0]     s1_idx_ff;
   logic [CfgW-1:0]     s1_cfg_ff;
   logic [EntAddrW-1:0] s1_eaddr_ff;
   logic [AddrW-1:0]    s1_caddr_ff;
   logic [LenW-1:0]     s1_len_ff;
   logic [KindW-1:0]    s1_kind_ff;
   logic [PrivW-1:0]    s1_priv_ff;

   // Result register
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_allowed_ff, rsp_allowed_in;

   logic req_fire, out_free, s1_adv, s1_write;

   logic [EntAddrW-1:0] region_addr_ff [ENTRIES];
   logic [CfgW-1:0]     region_cfg_ff  [ENTRIES];

   logic [Words-1:0][AddrW-1:0] word_addr;
   logic [Words-1:0]            active;
   logic [Words-1:0]            lt_chain [ENTRIES+1];
   match_type                   match    [ENTRIES];

   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_adv     = s1_valid_ff && ((s1_op_ff == OP_WRITE) || out_free);
   assign req_tready = !s1_valid_ff || s1_adv;
   assign s1_write   = s1_valid_ff && (s1_op_ff == OP_WRITE);

   always_comb begin
      s1_valid_in = req_fire ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_op_ff    <= op_type'(req_tuser);
         s1_idx_ff   <= req_tdata[IdxW-1:0];
         s1_cfg_ff   <= req_tdata[IdxW +: CfgW];
         s1_eaddr_ff <= req_tdata[IdxW+CfgW +: EntAddrW];
         s1_caddr_ff <= req_tdata[IdxW+CfgW+EntAddrW +: AddrW];
         s1_len_ff   <= req_tdata[IdxW+CfgW+EntAddrW+AddrW +: LenW];
         s1_kind_ff  <= req_tdata[IdxW+CfgW+EntAddrW+AddrW+LenW +: KindW];
         s1_priv_ff  <= req_tdata[IdxW+CfgW+EntAddrW+AddrW+LenW+KindW +: PrivW];
      end
   end

   // Entry table; a write lands as its beat leaves the input register
   for (genvar g = 0; g < ENTRIES; g++) begin : g_tbl
      always_ff @(posedge clock) begin
         if (reset) begin
            region_addr_ff[g] <= '0;
            region_cfg_ff[g]  <= '0;
         end else if (s1_write && (32'(s1_idx_ff) == g)) begin
            region_addr_ff[g] <= s1_eaddr_ff;
            region_cfg_ff[g]  <= s1_cfg_ff;
         end
      end
   end

   // Words touched by the access, one per four bytes of length
   always_comb begin
      for (int k = 0; k < Words; k++) begin
         word_addr[k] = s1_caddr_ff + AddrW'(WordBytes * k);
         active[k]    = s1_len_ff > LenW'(WordBytes * k);
      end
   end

   // Entry 0 has base 0, so no word is below its base
   assign lt_chain[0] = '0;

   for (genvar g = 0; g < ENTRIES; g++) begin : g_ent
      pmpc_entry u_entry (
         .entry_addr (region_addr_ff[g]),
         .entry_mode (region_cfg_ff[g][CfgModeLo +: 2]),
         .prev_lt    (lt_chain[g]),
         .word_addr  (word_addr),
         .match      (match[g])
      );
      assign lt_chain[g+1] = match[g].lt;
   end

   // Lowest-index entry with any word hit decides; a partial hit denies
   always_comb begin
      logic [Words-1:0] hits;
      rsp_allowed_in = (s1_priv_ff == PRIV_MACHINE);
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         hits = match[i].hit & active;
         if ((mode_type'(region_cfg_ff[i][CfgModeLo +: 2]) != MODE_OFF) && (|hits)) begin
            rsp_allowed_in = (hits == active) &&
                             permit(region_cfg_ff[i], s1_kind_ff, s1_priv_ff);
         end
      end
   end

   always_comb begin
      if (s1_valid_ff && (s1_op_ff == OP_CHECK) && out_free) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff && (s1_op_ff == OP_CHECK) && out_free) begin
         rsp_allowed_ff <= rsp_allowed_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RspDataW-1){1'b0}}, rsp_allowed_ff};

endmodule
